// ----- sv/fsrr_pkg.sv -----
// Shared types, widths and codes for the free-space round-robin selector.
package fsrr_pkg;

  localparam int unsigned MAX_SHARDS_DEF = 64;

  localparam int unsigned BS_W   = 21;
  localparam int unsigned BYTE_W = 48;
  localparam int unsigned CAP_W  = 32;
  localparam int unsigned SC_W   = 7;
  localparam int unsigned BLK_W  = 40;
  localparam int unsigned NEED_W = 50;
  localparam int unsigned DVD_W  = 64;
  localparam int unsigned IDXO_W = 6;
  localparam int unsigned CFGI_W = 3;

  // Register indexes
  localparam logic [CFGI_W-1:0] REG_BLOCK_SIZE = 3'd0;
  localparam logic [CFGI_W-1:0] REG_PRECISION  = 3'd1;
  localparam logic [CFGI_W-1:0] REG_DES_RES    = 3'd2;
  localparam logic [CFGI_W-1:0] REG_MIN_RES    = 3'd3;
  localparam logic [CFGI_W-1:0] REG_INIT_CAP   = 3'd4;
  localparam logic [CFGI_W-1:0] REG_SHARD_CNT  = 3'd5;

  // Result status codes
  localparam logic [1:0] ST_SELECTED = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_LOADED   = 2'd2;
  localparam logic [1:0] ST_MISMATCH = 2'd3;

  typedef struct packed {
    logic [BS_W-1:0]   block_size;
    logic [BYTE_W-1:0] precision_bytes;
    logic [BYTE_W-1:0] desired_reserve_bytes;
    logic [BYTE_W-1:0] min_reserve_bytes;
    logic [CAP_W-1:0]  initial_capacity_blocks;
    logic [SC_W-1:0]   shard_count;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dvd;
    logic [BYTE_W-1:0] dvs;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DVD_W-1:0]  quo;
    logic [BYTE_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic              valid;
    logic [1:0]        status;
    logic [IDXO_W-1:0] shard;
  } res_t;

endpackage

// ----- sv/fsrr_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
module fsrr_div (
  input  logic               clk,
  input  logic               rst_n,
  input  fsrr_pkg::div_req_t req,
  output fsrr_pkg::div_rsp_t rsp
);

  logic                        busy_r;
  logic                        done_r;
  logic [6:0]                  cnt_r;
  logic [fsrr_pkg::DVD_W-1:0]  quo_r;
  logic [fsrr_pkg::BYTE_W-1:0] rem_r;
  logic [fsrr_pkg::BYTE_W-1:0] dvs_r;
  logic [fsrr_pkg::BYTE_W:0]   trial;
  logic [fsrr_pkg::BYTE_W:0]   diff;
  logic                        ge;

  assign trial = {rem_r, quo_r[fsrr_pkg::DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'(fsrr_pkg::DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dvd;
      rem_r <= '0;
      dvs_r <= req.dvs;
    end else if (busy_r) begin
      quo_r <= {quo_r[fsrr_pkg::DVD_W-2:0], ge};
      rem_r <= ge ? diff[fsrr_pkg::BYTE_W-1:0] : trial[fsrr_pkg::BYTE_W-1:0];
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

// ----- sv/fsrr_seq.sv -----
// Sequencer: staging, commit sort, select search, all around one shared divider.
module fsrr_seq #(
  parameter int unsigned MAX_SHARDS = fsrr_pkg::MAX_SHARDS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fsrr_pkg::cfg_t              cfg,
  input  logic                        in_acc,
  input  logic                        in_action,
  input  logic [fsrr_pkg::BLK_W-1:0]  in_total,
  input  logic [fsrr_pkg::BLK_W-1:0]  in_used,
  input  logic                        in_last,
  input  logic [fsrr_pkg::BYTE_W-1:0] in_file,
  input  logic                        slot_free,
  output logic                        idle,
  output fsrr_pkg::res_t              res
);

  localparam int unsigned IW = (MAX_SHARDS > 1) ? $clog2(MAX_SHARDS) : 1;
  localparam int unsigned CW = $clog2(MAX_SHARDS + 2);
  localparam int unsigned BW = fsrr_pkg::BYTE_W;
  localparam int unsigned LW = fsrr_pkg::BLK_W;
  localparam int unsigned NW = fsrr_pkg::NEED_W;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_UNIT_GO = 5'd1;
  localparam logic [4:0] S_UNIT_W  = 5'd2;
  localparam logic [4:0] S_BYT_GO  = 5'd3;
  localparam logic [4:0] S_BYT_W   = 5'd4;
  localparam logic [4:0] S_NEED_GO = 5'd5;
  localparam logic [4:0] S_NEED_W  = 5'd6;
  localparam logic [4:0] S_INIT_GO = 5'd7;
  localparam logic [4:0] S_INIT_W  = 5'd8;
  localparam logic [4:0] S_CNT_RD  = 5'd9;
  localparam logic [4:0] S_CNT_EV  = 5'd10;
  localparam logic [4:0] S_CHK     = 5'd11;
  localparam logic [4:0] S_MOD_GO  = 5'd12;
  localparam logic [4:0] S_MOD_W   = 5'd13;
  localparam logic [4:0] S_PICK_RD = 5'd14;
  localparam logic [4:0] S_PICK_EV = 5'd15;
  localparam logic [4:0] S_SC_RD   = 5'd16;
  localparam logic [4:0] S_SC_GO   = 5'd17;
  localparam logic [4:0] S_SC_W    = 5'd18;
  localparam logic [4:0] S_RK_RDI  = 5'd19;
  localparam logic [4:0] S_RK_EVI  = 5'd20;
  localparam logic [4:0] S_RK_RD   = 5'd21;
  localparam logic [4:0] S_RK_EV   = 5'd22;
  localparam logic [4:0] S_RK_WR   = 5'd23;
  localparam logic [4:0] S_DONE    = 5'd24;

  logic [4:0]    state_r, state_nxt;
  logic          op_commit_r, op_commit_nxt;
  logic          pass_r, pass_nxt;
  logic [BW-1:0] unit_r, unit_nxt;
  logic [BW:0]   t_r, t_nxt;
  logic [NW-1:0] need_r, need_nxt;
  logic [CW-1:0] c_r, c_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic [IW-1:0] j_r, j_nxt;
  logic [IW-1:0] rank_r, rank_nxt;
  logic [LW-1:0] si_r, si_nxt;
  logic [CW-1:0] stg_cnt_r, stg_cnt_nxt;
  logic          loaded_r, loaded_nxt;
  logic [CW-1:0] lcnt_r, lcnt_nxt;
  logic [63:0]   ctr_r, ctr_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [IW-1:0] shard_r, shard_nxt;
  logic [BW-1:0] file_r, file_nxt;

  logic [LW-1:0] stg_mem [MAX_SHARDS];
  logic [LW-1:0] srt_sc_mem [MAX_SHARDS];
  logic [IW-1:0] srt_id_mem [MAX_SHARDS];
  logic [LW-1:0] stg_rd_r;
  logic [LW-1:0] sc_rd_r;
  logic [IW-1:0] id_rd_r;

  logic          stg_we;
  logic [IW-1:0] stg_wa;
  logic [LW-1:0] stg_wd;
  logic [IW-1:0] stg_ra;
  logic          srt_we;
  logic [IW-1:0] srt_ra;

  fsrr_pkg::div_req_t dreq;
  fsrr_pkg::div_rsp_t drsp;

  logic [fsrr_pkg::BS_W-1:0] eb;
  logic [BW-1:0]             uq;
  logic                      rnd;
  logic [NW-1:0]             score;
  logic [BW:0]               bytes;
  logic [CW-1:0]             n_sel;
  logic [CW-1:0]             n_cur;
  logic [LW-1:0]             freeb;
  logic [CW-1:0]             stg_inc;
  logic                      match;

  fsrr_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .rsp  (drsp)
  );

  assign eb    = (cfg.block_size == '0) ? fsrr_pkg::BS_W'(1) : cfg.block_size;
  assign uq    = drsp.quo[BW-1:0];
  assign rnd   = {drsp.rem, 1'b0} >= {1'b0, unit_r};
  assign score = drsp.quo[NW-1:0] + NW'(rnd);
  assign bytes = {1'b0, file_r} +
                 {1'b0, pass_r ? cfg.min_reserve_bytes : cfg.desired_reserve_bytes};
  assign n_sel = (32'(cfg.shard_count) > 32'(MAX_SHARDS)) ? CW'(MAX_SHARDS)
                                                          : CW'(cfg.shard_count);
  assign n_cur = loaded_r ? lcnt_r : n_sel;
  assign freeb = in_total - ((in_used < in_total) ? in_used : in_total);
  assign stg_inc = (32'(stg_cnt_r) < 32'(MAX_SHARDS)) ? stg_cnt_r + CW'(1)
                                                      : CW'(MAX_SHARDS + 1);
  assign match = (32'(stg_inc) <= 32'(MAX_SHARDS)) &&
                 (32'(stg_inc) == 32'(cfg.shard_count));
  assign idle  = (state_r == S_IDLE);

  // Divider operand select
  always_comb begin
    dreq.start = 1'b0;
    dreq.dvd   = '0;
    dreq.dvs   = BW'(eb);
    unique case (state_r)
      S_UNIT_GO: begin
        dreq.start = 1'b1;
        dreq.dvd   = fsrr_pkg::DVD_W'(cfg.precision_bytes);
      end
      S_BYT_GO: begin
        dreq.start = 1'b1;
        dreq.dvd   = fsrr_pkg::DVD_W'(bytes);
      end
      S_NEED_GO: begin
        dreq.start = 1'b1;
        dreq.dvd   = fsrr_pkg::DVD_W'(t_r);
        dreq.dvs   = unit_r;
      end
      S_INIT_GO: begin
        dreq.start = 1'b1;
        dreq.dvd   = fsrr_pkg::DVD_W'(cfg.initial_capacity_blocks);
        dreq.dvs   = unit_r;
      end
      S_MOD_GO: begin
        dreq.start = 1'b1;
        dreq.dvd   = ctr_r;
        dreq.dvs   = BW'(c_r);
      end
      S_SC_GO: begin
        dreq.start = 1'b1;
        dreq.dvd   = fsrr_pkg::DVD_W'(stg_rd_r);
        dreq.dvs   = unit_r;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    op_commit_nxt = op_commit_r;
    pass_nxt      = pass_r;
    unit_nxt      = unit_r;
    t_nxt         = t_r;
    need_nxt      = need_r;
    c_nxt         = c_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    rank_nxt      = rank_r;
    si_nxt        = si_r;
    stg_cnt_nxt   = stg_cnt_r;
    loaded_nxt    = loaded_r;
    lcnt_nxt      = lcnt_r;
    ctr_nxt       = ctr_r;
    status_nxt    = status_r;
    shard_nxt     = shard_r;
    file_nxt      = file_r;
    stg_we        = 1'b0;
    stg_wa        = stg_cnt_r[IW-1:0];
    stg_wd        = freeb;
    stg_ra        = i_r;
    srt_we        = 1'b0;
    srt_ra        = j_r;
    res.valid     = 1'b0;
    res.status    = status_r;
    res.shard     = fsrr_pkg::IDXO_W'(shard_r);

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          shard_nxt = '0;
          if (!in_action) begin
            stg_we      = 32'(stg_cnt_r) < 32'(MAX_SHARDS);
            stg_cnt_nxt = stg_inc;
            status_nxt  = fsrr_pkg::ST_LOADED;
            state_nxt   = S_DONE;
            if (in_last) begin
              stg_cnt_nxt = '0;
              if (match) begin
                n_nxt         = stg_inc;
                op_commit_nxt = 1'b1;
                state_nxt     = S_UNIT_GO;
              end else begin
                status_nxt = fsrr_pkg::ST_MISMATCH;
              end
            end
          end else begin
            file_nxt      = in_file;
            pass_nxt      = 1'b0;
            op_commit_nxt = 1'b0;
            state_nxt     = S_UNIT_GO;
          end
        end
      end
      S_UNIT_GO: state_nxt = S_UNIT_W;
      S_UNIT_W: begin
        if (drsp.done) begin
          unit_nxt = (uq == '0) ? BW'(1) : uq;
          if (op_commit_r) begin
            i_nxt     = '0;
            state_nxt = S_SC_RD;
          end else begin
            state_nxt = S_BYT_GO;
          end
        end
      end
      S_BYT_GO: state_nxt = S_BYT_W;
      S_BYT_W: begin
        if (drsp.done) begin
          t_nxt     = drsp.quo[BW:0];
          state_nxt = S_NEED_GO;
        end
      end
      S_NEED_GO: state_nxt = S_NEED_W;
      S_NEED_W: begin
        if (drsp.done) begin
          need_nxt = score;
          c_nxt    = '0;
          j_nxt    = '0;
          if (!loaded_r) begin
            state_nxt = S_INIT_GO;
          end else if (n_cur == '0) begin
            state_nxt = S_CHK;
          end else begin
            state_nxt = S_CNT_RD;
          end
        end
      end
      S_INIT_GO: state_nxt = S_INIT_W;
      S_INIT_W: begin
        if (drsp.done) begin
          c_nxt     = (score >= need_r) ? n_cur : '0;
          state_nxt = S_CHK;
        end
      end
      S_CNT_RD: begin
        srt_ra    = j_r;
        state_nxt = S_CNT_EV;
      end
      S_CNT_EV: begin
        if (NW'(sc_rd_r) >= need_r) begin
          c_nxt = c_r + CW'(1);
        end
        j_nxt     = j_r + IW'(1);
        state_nxt = (CW'(j_r) == n_cur - CW'(1)) ? S_CHK : S_CNT_RD;
      end
      S_CHK: begin
        if (c_r == '0) begin
          if (!pass_r) begin
            pass_nxt  = 1'b1;
            state_nxt = S_BYT_GO;
          end else begin
            status_nxt = fsrr_pkg::ST_NO_SPACE;
            state_nxt  = S_DONE;
          end
        end else begin
          state_nxt = S_MOD_GO;
        end
      end
      S_MOD_GO: state_nxt = S_MOD_W;
      S_MOD_W: begin
        if (drsp.done) begin
          ctr_nxt    = ctr_r + 64'd1;
          status_nxt = fsrr_pkg::ST_SELECTED;
          shard_nxt  = drsp.rem[IW-1:0];
          state_nxt  = loaded_r ? S_PICK_RD : S_DONE;
        end
      end
      S_PICK_RD: begin
        srt_ra    = shard_r;
        state_nxt = S_PICK_EV;
      end
      S_PICK_EV: begin
        shard_nxt = id_rd_r;
        state_nxt = S_DONE;
      end
      S_SC_RD: begin
        stg_ra    = i_r;
        state_nxt = S_SC_GO;
      end
      S_SC_GO: state_nxt = S_SC_W;
      S_SC_W: begin
        if (drsp.done) begin
          stg_we = 1'b1;
          stg_wa = i_r;
          stg_wd = score[LW-1:0];
          if (CW'(i_r) == n_r - CW'(1)) begin
            i_nxt     = '0;
            state_nxt = S_RK_RDI;
          end else begin
            i_nxt     = i_r + IW'(1);
            state_nxt = S_SC_RD;
          end
        end
      end
      S_RK_RDI: begin
        stg_ra    = i_r;
        state_nxt = S_RK_EVI;
      end
      S_RK_EVI: begin
        si_nxt    = stg_rd_r;
        j_nxt     = '0;
        rank_nxt  = '0;
        state_nxt = S_RK_RD;
      end
      S_RK_RD: begin
        stg_ra    = j_r;
        state_nxt = S_RK_EV;
      end
      S_RK_EV: begin
        if ((stg_rd_r > si_r) || ((stg_rd_r == si_r) && (j_r < i_r))) begin
          rank_nxt = rank_r + IW'(1);
        end
        j_nxt     = j_r + IW'(1);
        state_nxt = (CW'(j_r) == n_r - CW'(1)) ? S_RK_WR : S_RK_RD;
      end
      S_RK_WR: begin
        srt_we = 1'b1;
        if (CW'(i_r) == n_r - CW'(1)) begin
          loaded_nxt = 1'b1;
          lcnt_nxt   = n_r;
          status_nxt = fsrr_pkg::ST_LOADED;
          state_nxt  = S_DONE;
        end else begin
          i_nxt     = i_r + IW'(1);
          state_nxt = S_RK_RDI;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          res.valid = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      stg_cnt_r   <= '0;
      loaded_r    <= 1'b0;
      lcnt_r      <= '0;
      ctr_r       <= '0;
      op_commit_r <= 1'b0;
      pass_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stg_cnt_r   <= stg_cnt_nxt;
      loaded_r    <= loaded_nxt;
      lcnt_r      <= lcnt_nxt;
      ctr_r       <= ctr_nxt;
      op_commit_r <= op_commit_nxt;
      pass_r      <= pass_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unit_r   <= unit_nxt;
    t_r      <= t_nxt;
    need_r   <= need_nxt;
    c_r      <= c_nxt;
    n_r      <= n_nxt;
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    rank_r   <= rank_nxt;
    si_r     <= si_nxt;
    status_r <= status_nxt;
    shard_r  <= shard_nxt;
    file_r   <= file_nxt;
  end

  always_ff @(posedge clk) begin
    if (stg_we) begin
      stg_mem[stg_wa] <= stg_wd;
    end
    stg_rd_r <= stg_mem[stg_ra];
  end

  always_ff @(posedge clk) begin
    if (srt_we) begin
      srt_sc_mem[rank_r] <= si_r;
      srt_id_mem[rank_r] <= i_r;
    end
    sc_rd_r <= srt_sc_mem[srt_ra];
    id_rd_r <= srt_id_mem[srt_ra];
  end

  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    dreq.start |-> !drsp.busy)
    else $error("divider started while busy");

  a_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |=> state_r == S_IDLE)
    else $error("sequencer did not return to idle after result");

  a_mod_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD_W && drsp.done) |-> drsp.rem < BW'(c_r))
    else $error("round-robin pick out of range");

  a_stg_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    32'(stg_cnt_r) <= 32'(MAX_SHARDS + 1))
    else $error("staging count beyond saturation");

endmodule

// ----- sv/free_space_round_robin_selector.sv -----
// Top level of the free-space round-robin shard selector.
// Usage:
//   in_* channel (valid/stall): each item either loads one shard statistic
//   (in_action low) or asks for a shard to hold a file (in_action high).
//   Loads arrive in shard-index order; the one with in_last_stat high commits
//   the staged set if its size equals shard_count, scoring and sorting it.
//   out_* channel (valid/stall): exactly one result per item, in order.
//   cfg_* channel (valid/ready): register writes, to be issued only while no
//   item is in work; cfg_ready is always high.
// Work: a load that does not commit goes straight to its result. Each division
//   runs on the shared divider. A select runs three divisions on the first
//   reserve pass and two on the second, plus one table read per entry for
//   the fit count (one division instead before the first commit) and one
//   more division for the pick. A commit runs one division for the unit and
//   one per shard for its score, then compares each score with every entry.
//   The single divider and the one-port tables serialise this work; one item
//   is in work at a time and in_stall is high until it finishes.
// Reset: config registers return to their defaults, staging and the table
//   are empty, and the first selects use initial_capacity_blocks per shard.
// Receiver stall: a finished result waits in the output register; the
//   sequencer holds its next result until that register has drained.
module free_space_round_robin_selector #(
  parameter int unsigned MAX_SHARDS = fsrr_pkg::MAX_SHARDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_action,
  input  logic [fsrr_pkg::BLK_W-1:0]    in_total_blocks,
  input  logic [fsrr_pkg::BLK_W-1:0]    in_used_blocks,
  input  logic                          in_last_stat,
  input  logic [fsrr_pkg::BYTE_W-1:0]   in_file_size,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [fsrr_pkg::IDXO_W-1:0]   out_shard_index,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fsrr_pkg::CFGI_W-1:0]   cfg_index,
  input  logic [fsrr_pkg::BYTE_W-1:0]   cfg_data
);

  fsrr_pkg::cfg_t cfg_r;
  fsrr_pkg::res_t res;
  logic           idle;
  logic           in_acc;
  logic           slot_free;
  logic           out_valid_r;
  logic [1:0]     status_r;
  logic [fsrr_pkg::IDXO_W-1:0] shard_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = !idle;
  assign in_acc    = in_valid && idle;
  // Output register can take a result when empty or draining this cycle.
  assign slot_free = !out_valid_r || !out_stall;

  // Config registers: decode the index, drop writes beyond the list.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.block_size              <= fsrr_pkg::BS_W'(4096);
      cfg_r.precision_bytes         <= fsrr_pkg::BYTE_W'(4096);
      cfg_r.desired_reserve_bytes   <= '0;
      cfg_r.min_reserve_bytes       <= '0;
      cfg_r.initial_capacity_blocks <= '1;
      cfg_r.shard_count             <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fsrr_pkg::REG_BLOCK_SIZE: cfg_r.block_size <= cfg_data[fsrr_pkg::BS_W-1:0];
        fsrr_pkg::REG_PRECISION:  cfg_r.precision_bytes <= cfg_data;
        fsrr_pkg::REG_DES_RES:    cfg_r.desired_reserve_bytes <= cfg_data;
        fsrr_pkg::REG_MIN_RES:    cfg_r.min_reserve_bytes <= cfg_data;
        fsrr_pkg::REG_INIT_CAP:
          cfg_r.initial_capacity_blocks <= cfg_data[fsrr_pkg::CAP_W-1:0];
        fsrr_pkg::REG_SHARD_CNT:  cfg_r.shard_count <= cfg_data[fsrr_pkg::SC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  fsrr_seq #(
    .MAX_SHARDS(MAX_SHARDS)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_acc   (in_acc),
    .in_action(in_action),
    .in_total (in_total_blocks),
    .in_used  (in_used_blocks),
    .in_last  (in_last_stat),
    .in_file  (in_file_size),
    .slot_free(slot_free),
    .idle     (idle),
    .res      (res)
  );

  // Output register: load on a new result, drop once transferred.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      status_r <= res.status;
      shard_r  <= res.shard;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_shard_index = shard_r;

endmodule

// ----- tb/fsrr_checker.sv -----
// Checker for the free-space round-robin selector: watches the channels, predicts, compares.
`timescale 1ns / 1ps
module fsrr_checker #(
  parameter int unsigned MAX_SHARDS = fsrr_pkg::MAX_SHARDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          in_action,
  input  logic [fsrr_pkg::BLK_W-1:0]    in_total_blocks,
  input  logic [fsrr_pkg::BLK_W-1:0]    in_used_blocks,
  input  logic                          in_last_stat,
  input  logic [fsrr_pkg::BYTE_W-1:0]   in_file_size,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [1:0]                    out_status,
  input  logic [fsrr_pkg::IDXO_W-1:0]   out_shard_index,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [fsrr_pkg::CFGI_W-1:0]   cfg_index,
  input  logic [fsrr_pkg::BYTE_W-1:0]   cfg_data,
  output int                            fail_count,
  output int                            pending
);

  typedef struct {
    logic [1:0]                  status;
    logic [fsrr_pkg::IDXO_W-1:0] shard;
  } pick_t;

  pick_t picks_due[$];

  logic [fsrr_pkg::BS_W-1:0]   blk_size;
  logic [fsrr_pkg::BYTE_W-1:0] precision;
  logic [fsrr_pkg::BYTE_W-1:0] desired_res;
  logic [fsrr_pkg::BYTE_W-1:0] min_res;
  logic [fsrr_pkg::CAP_W-1:0]  init_cap;
  logic [fsrr_pkg::SC_W-1:0]   shards_cfg;

  logic [fsrr_pkg::BLK_W-1:0]  staged_free[MAX_SHARDS];
  int unsigned                 staged_n;
  logic [63:0]                 rank_score[MAX_SHARDS];
  logic [fsrr_pkg::IDXO_W-1:0] rank_shard[MAX_SHARDS];
  bit                          table_valid;
  int unsigned                 table_n;
  logic [63:0]                 rr_counter;

  function automatic logic [63:0] eff_block();
    return (blk_size == 0) ? 64'd1 : 64'(blk_size);
  endfunction

  // Round to nearest in units of precision/block, ties up.
  function automatic logic [63:0] score(logic [63:0] x);
    logic [63:0] unit;
    logic [63:0] q;
    logic [63:0] r;
    unit = 64'(precision) / eff_block();
    if (unit == 0) unit = 1;
    q = x / unit;
    r = x % unit;
    if (r >= unit - r) q++;
    return q;
  endfunction

  function automatic int unsigned shards_fitting(logic [63:0] bytes);
    logic [63:0] need;
    int unsigned n;
    int unsigned c;
    need = score(bytes / eff_block());
    c = 0;
    if (!table_valid) begin
      n = (shards_cfg > MAX_SHARDS) ? MAX_SHARDS : shards_cfg;
      return (score(64'(init_cap)) >= need) ? n : 0;
    end
    for (int i = 0; i < table_n; i++)
      if (rank_score[i] >= need) c++;
    return c;
  endfunction

  // Insertion sort by score descending; equal scores keep index order.
  function automatic void commit_table(int unsigned n);
    logic [63:0] s;
    int j;
    for (int i = 0; i < n; i++) begin
      s = score(64'(staged_free[i]));
      j = i;
      while (j > 0 && rank_score[j-1] < s) begin
        rank_score[j] = rank_score[j-1];
        rank_shard[j] = rank_shard[j-1];
        j--;
      end
      rank_score[j] = s;
      rank_shard[j] = fsrr_pkg::IDXO_W'(i);
    end
    table_n = n;
    table_valid = 1;
  endfunction

  function automatic pick_t predict_item();
    pick_t p;
    logic [fsrr_pkg::BLK_W-1:0] freeb;
    int unsigned c;
    p.shard = '0;
    if (!in_action) begin
      freeb = in_total_blocks - ((in_used_blocks < in_total_blocks) ? in_used_blocks
                                                                     : in_total_blocks);
      if (staged_n < MAX_SHARDS) begin
        staged_free[staged_n] = freeb;
        staged_n++;
      end else begin
        staged_n = MAX_SHARDS + 1;
      end
      p.status = fsrr_pkg::ST_LOADED;
      if (in_last_stat) begin
        if (staged_n <= MAX_SHARDS && staged_n == shards_cfg) commit_table(staged_n);
        else p.status = fsrr_pkg::ST_MISMATCH;
        staged_n = 0;
      end
    end else begin
      c = shards_fitting(64'(in_file_size) + 64'(desired_res));
      if (c == 0) c = shards_fitting(64'(in_file_size) + 64'(min_res));
      if (c == 0) begin
        p.status = fsrr_pkg::ST_NO_SPACE;
      end else begin
        p.status = fsrr_pkg::ST_SELECTED;
        p.shard = table_valid ? rank_shard[rr_counter % c]
                              : fsrr_pkg::IDXO_W'(rr_counter % c);
        rr_counter++;
      end
    end
    return p;
  endfunction

  always @(posedge clk) begin : watch
    pick_t got;
    pick_t want;
    if (!rst_n) begin
      blk_size    = fsrr_pkg::BS_W'(4096);
      precision   = fsrr_pkg::BYTE_W'(4096);
      desired_res = '0;
      min_res     = '0;
      init_cap    = '1;
      shards_cfg  = '0;
      staged_n    = 0;
      table_valid = 0;
      table_n     = 0;
      rr_counter  = 0;
      picks_due.delete();
      pending     <= 0;
      fail_count  <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          fsrr_pkg::REG_BLOCK_SIZE: blk_size    = cfg_data[fsrr_pkg::BS_W-1:0];
          fsrr_pkg::REG_PRECISION:  precision   = cfg_data;
          fsrr_pkg::REG_DES_RES:    desired_res = cfg_data;
          fsrr_pkg::REG_MIN_RES:    min_res     = cfg_data;
          fsrr_pkg::REG_INIT_CAP:   init_cap    = cfg_data[fsrr_pkg::CAP_W-1:0];
          fsrr_pkg::REG_SHARD_CNT:  shards_cfg  = cfg_data[fsrr_pkg::SC_W-1:0];
          default: ;
        endcase
      end
      // Retire the oldest expectation before queueing a new one.
      if (out_valid && !out_stall) begin
        got.status = out_status;
        got.shard = out_shard_index;
        if (picks_due.size() == 0) begin
          $error("unexpected result: status %0d shard %0d", got.status, got.shard);
          fail_count <= fail_count + 1;
        end else begin
          want = picks_due.pop_front();
          if (got.status !== want.status) begin
            $error("status mismatch: expected %0d actual %0d", want.status, got.status);
            fail_count <= fail_count + 1;
          end else if (got.shard !== want.shard) begin
            $error("shard_index mismatch: expected %0d actual %0d", want.shard, got.shard);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) picks_due = {picks_due, predict_item()};
      pending <= picks_due.size();
    end
  end

endmodule

// ----- tb/tb.sv -----
// Testbench top for the free-space round-robin selector: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb;

  localparam int CYCLE_LIMIT  = 8000000;
  localparam int TARGET_ITEMS = 1250;
  // Receiver behavior windows, in cycles.
  localparam int HOLD_AT   = 30000;
  localparam int HOLD_LEN  = 6000;
  localparam int CALM_FROM = 60000;
  localparam int CALM_TO   = 90000;

  logic                        clk = 0;
  logic                        rst_n = 0;
  logic                        in_valid = 0;
  logic                        in_stall;
  logic                        in_action = 0;
  logic [fsrr_pkg::BLK_W-1:0]  in_total_blocks = '0;
  logic [fsrr_pkg::BLK_W-1:0]  in_used_blocks = '0;
  logic                        in_last_stat = 0;
  logic [fsrr_pkg::BYTE_W-1:0] in_file_size = '0;
  logic                        out_valid;
  logic                        out_stall = 0;
  logic [1:0]                  out_status;
  logic [fsrr_pkg::IDXO_W-1:0] out_shard_index;
  logic                        cfg_valid = 0;
  logic                        cfg_ready;
  logic [fsrr_pkg::CFGI_W-1:0] cfg_index = '0;
  logic [fsrr_pkg::BYTE_W-1:0] cfg_data = '0;

  int fail_count;
  int pending;
  int cycle = 0;
  int hold_left = 0;
  int items_sent = 0;
  int phases = 0;
  bit sender_calm = 0;
  int unsigned shards_now = 0;

  free_space_round_robin_selector dut (.*);

  fsrr_checker u_checker (.*);

  always #5 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: random stalls, one long hold-off to back the block up, then a calm stretch.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1;
      hold_left <= hold_left - 1;
    end else if (cycle == HOLD_AT) begin
      out_stall <= 1;
      hold_left <= HOLD_LEN;
    end else if (cycle >= CALM_FROM && cycle < CALM_TO) begin
      out_stall <= 0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 31);
    end
  end

  // Random value of random magnitude, now and then all ones.
  function automatic logic [63:0] rnd_val(int w);
    logic [63:0] v;
    v = {$urandom, $urandom};
    v = v >> $urandom_range(0, 63);
    if ($urandom_range(0, 15) == 0) v = '1;
    if (w < 64) v &= (64'd1 << w) - 1;
    return v;
  endfunction

  // Offer one transfer and hold it until accepted; valid stays high afterwards.
  task automatic send_item(logic act, logic [63:0] tot, logic [63:0] used,
                           logic last, logic [63:0] file);
    if (!sender_calm && $urandom_range(0, 99) < 31) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid        <= 1;
    in_action       <= act;
    in_total_blocks <= tot[fsrr_pkg::BLK_W-1:0];
    in_used_blocks  <= used[fsrr_pkg::BLK_W-1:0];
    in_last_stat    <= last;
    in_file_size    <= file[fsrr_pkg::BYTE_W-1:0];
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic load(logic [63:0] tot, logic [63:0] used, logic last);
    send_item(1'b0, tot, used, last, rnd_val(fsrr_pkg::BYTE_W));
  endtask

  task automatic pick(logic [63:0] file);
    send_item(1'b1, rnd_val(fsrr_pkg::BLK_W), rnd_val(fsrr_pkg::BLK_W),
              1'($urandom_range(0, 1)), file);
  endtask

  // Drop valid and wait until every expected result is back.
  task automatic settle();
    in_valid <= 0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
  endtask

  // Hold cfg_valid across back-to-back writes; the caller lowers it.
  task automatic write_reg(logic [fsrr_pkg::CFGI_W-1:0] idx, logic [63:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val[fsrr_pkg::BYTE_W-1:0];
    if (idx == fsrr_pkg::REG_SHARD_CNT) shards_now = val[fsrr_pkg::SC_W-1:0];
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic random_config();
    case ($urandom_range(0, 4))
      0: write_reg(fsrr_pkg::REG_BLOCK_SIZE, 0);
      1: write_reg(fsrr_pkg::REG_BLOCK_SIZE, 1);
      2: write_reg(fsrr_pkg::REG_BLOCK_SIZE, 4096);
      3: write_reg(fsrr_pkg::REG_BLOCK_SIZE, (1 << fsrr_pkg::BS_W) - 1);
      default: write_reg(fsrr_pkg::REG_BLOCK_SIZE, rnd_val(fsrr_pkg::BS_W));
    endcase
    write_reg(fsrr_pkg::REG_PRECISION,
              ($urandom_range(0, 7) == 0) ? '0 : rnd_val(fsrr_pkg::BYTE_W));
    write_reg(fsrr_pkg::REG_DES_RES, rnd_val(fsrr_pkg::BYTE_W));
    write_reg(fsrr_pkg::REG_MIN_RES,
              ($urandom_range(0, 3) == 0) ? '0 : rnd_val(fsrr_pkg::BYTE_W));
    write_reg(fsrr_pkg::REG_INIT_CAP, rnd_val(fsrr_pkg::CAP_W));
    case ($urandom_range(0, 9))
      0: write_reg(fsrr_pkg::REG_SHARD_CNT, 0);
      1: write_reg(fsrr_pkg::REG_SHARD_CNT, fsrr_pkg::MAX_SHARDS_DEF);
      2: write_reg(fsrr_pkg::REG_SHARD_CNT,
                   $urandom_range(fsrr_pkg::MAX_SHARDS_DEF + 1, 127));
      default: write_reg(fsrr_pkg::REG_SHARD_CNT, $urandom_range(1, 8));
    endcase
    cfg_valid <= 0;
  endtask

  // Loads in shard order, the final one flagged last.
  task automatic load_run(int n);
    for (int i = 0; i < n; i++)
      load(rnd_val(fsrr_pkg::BLK_W), rnd_val(fsrr_pkg::BLK_W), i == n - 1);
  endtask

  initial begin
    int runlen;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: empty table at reset defaults, then clamp of an oversized shard count.
    pick(0);
    settle();
    write_reg(fsrr_pkg::REG_SHARD_CNT, 127);
    cfg_valid <= 0;
    pick(0);
    pick('1);
    settle();
    // Zero block size and zero precision both fall back to one.
    write_reg(fsrr_pkg::REG_SHARD_CNT, 3);
    write_reg(fsrr_pkg::REG_BLOCK_SIZE, 0);
    write_reg(fsrr_pkg::REG_PRECISION, 0);
    cfg_valid <= 0;
    pick(1000);
    pick(1000);
    settle();
    write_reg(fsrr_pkg::REG_BLOCK_SIZE, 4096);
    write_reg(fsrr_pkg::REG_PRECISION, 4096);
    write_reg(fsrr_pkg::REG_DES_RES, '1);
    write_reg(fsrr_pkg::REG_MIN_RES, 0);
    cfg_valid <= 0;
    // Commit three shards: full capacity, used above total, partly used.
    load('1, 0, 0);
    load(5, 9, 0);
    load(100, 40, 1);
    pick(0);
    pick(4096 * 50);
    pick('1);
    // Wrong counts leave the table alone.
    load(10, 1, 0);
    load(10, 2, 1);
    load(7, 0, 1);
    pick(4096);
    settle();
    write_reg(fsrr_pkg::REG_BLOCK_SIZE, (1 << fsrr_pkg::BS_W) - 1);
    write_reg(fsrr_pkg::REG_PRECISION, '1);
    write_reg(fsrr_pkg::REG_MIN_RES, '1);
    write_reg(fsrr_pkg::REG_INIT_CAP, 0);
    cfg_valid <= 0;
    pick(0);
    pick('1);
    load('1, '1, 0);
    load(0, 0, 0);
    load('1, 0, 1);
    pick(12345);

    // Random phases: mostly well-formed load runs and selects, some broken runs.
    while (items_sent < TARGET_ITEMS) begin
      settle();
      random_config();
      phases++;
      sender_calm = (phases % 6 == 3);
      repeat ($urandom_range(30, 70)) begin
        if (items_sent < TARGET_ITEMS) begin
          case ($urandom_range(0, 99)) inside
            [0:14]: begin
              runlen = (shards_now >= 1 && shards_now <= fsrr_pkg::MAX_SHARDS_DEF)
                       ? shards_now : $urandom_range(1, 5);
              load_run(runlen);
            end
            [15:19]: load_run(($urandom_range(0, 9) == 0) ? fsrr_pkg::MAX_SHARDS_DEF + 2
                                                         : $urandom_range(1, 8));
            default: pick(rnd_val(fsrr_pkg::BYTE_W));
          endcase
        end
      end
    end

    settle();
    $display("Ran %0d items over %0d random configuration phases plus directed cases.",
             items_sent, phases);
    $display("Covered loads, commits, count errors, staging overflow and round-robin picks.");
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
